FILE: rtl/gaussian_blur_downsample_3x_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef GAUSSIAN_BLUR_DOWNSAMPLE_3X_MACROS_SVH
`define GAUSSIAN_BLUR_DOWNSAMPLE_3X_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define GBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gbd_pkg.sv
package gbd_pkg;

  localparam int CH_BITS    = 16;
  localparam int ACC_BITS   = CH_BITS + 4;
  localparam int CFG_BITS   = 10;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;
  localparam int FIR_ACC_W  = 33;
  localparam int NUM_TAPS   = 5;
  localparam logic [CH_BITS-1:0] CH_MAX = {CH_BITS{1'b1}};

  localparam logic [14:0] GAUSS_TAPS [NUM_TAPS] = '{15'd7871, 15'd15329, 15'd19209,
                                                    15'd15329, 15'd7871};

  // ceil(2^23 / 9): exact quotient for every block sum plus rounding bias
  localparam int DIV9_SHIFT = 23;
  localparam logic [19:0] DIV9_RECIP = 20'd932068;

  typedef logic [CH_BITS-1:0]  chan_t;
  typedef chan_t [2:0]         rgb_t;
  typedef chan_t [NUM_TAPS-1:0] win_t;
  typedef win_t [2:0]          rgb_win_t;
  typedef logic [ACC_BITS-1:0] acc_t;
  typedef acc_t [2:0]          accs_t;

  typedef enum logic {
    REG_OUT_WIDTH  = 1'b0,
    REG_OUT_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

FILE: rtl/gaussian_blur_downsample_3x.sv
// Channel  Dir  Handshake                Payload
// s_       in   s_tvalid / s_tready      s_tdata: red_in, green_in, blue_in
// m_       out  m_tvalid / m_tready      m_tdata: pixel_x, pixel_y, rgb; m_tlast: frame_done
// cfg_     in   cfg_we                   cfg_index, cfg_data
//
// An item reads its raw column taps, then runs its column and row passes, if any; the last
// sample of the frame runs the most (three column passes, nine row passes). Each 5-tap
// pass runs on the shared MAC unit.
// Reset is synchronous; no clearing pass, stores are valid once written.
// A pending result holds in the output register; the block stalls only when a
// second result is ready before the first was taken.
module gaussian_blur_downsample_3x #(
  parameter int MAX_OUT_ROWS = 512,
  parameter int MAX_OUT_COLS = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gbd_pkg::IN_DATA_W-1:0]     s_tdata,   // red_in, green_in, blue_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gbd_pkg::OUT_DATA_W-1:0]    m_tdata,   // pixel_x, pixel_y, red, green, blue
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  gbd_pkg::reg_idx_t                 cfg_index,
  input  logic [gbd_pkg::CFG_BITS-1:0]      cfg_data
);
  import gbd_pkg::*;
  `include "gaussian_blur_downsample_3x_macros.svh"

  localparam int RW = $clog2(3 * MAX_OUT_ROWS);
  localparam int CW = $clog2(3 * MAX_OUT_COLS);
  localparam int AW = $clog2(MAX_OUT_ROWS);
  localparam int BW = $clog2(MAX_OUT_COLS);
  localparam int WW = $clog2(MAX_OUT_COLS + 1);
  localparam int HW = $clog2(MAX_OUT_ROWS + 1);
  localparam int RAW_AW = RW + 2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RAW  = 9'b000000010,
    S_LANE = 9'b000000100,
    S_CFIR = 9'b000001000,
    S_ROW  = 9'b000010000,
    S_RFIR = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_EMIT = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t          state;
  logic [WW-1:0]   out_width;
  logic [HW-1:0]   out_height;
  logic [CW-1:0]   c;
  logic [RW-1:0]   r;
  logic [BW-1:0]   cq;
  logic [1:0]      cm;
  logic [AW-1:0]   rq;
  logic [1:0]      rm;
  logic [2:0]      rk;
  logic [1:0]      lane;
  logic [1:0]      m;

  rgb_t            cur;
  rgb_t            e    [4];
  rgb_t            ex   [7];
  rgb_t            rbw  [3][4];
  rgb_t            fbuf [7];

  logic [AW-1:0]   by_r;
  logic [BW-1:0]   bx_r;
  logic            first_r;
  logic            emit_r;
  accs_t           sums_r;
  logic [40:0]     prod [3];

  logic [CW:0]     w3;
  logic [RW:0]     h3;
  logic            last_col;
  logic            last_row;
  logic            lane_ok;
  logic            row_ok;
  logic [1:0]      rd_k;
  logic [1:0]      cap_k;
  logic [CW-1:0]   rd_col;
  logic [CW-1:0]   cap_col;
  logic [1:0]      dcol;
  logic [1:0]      drow;
  logic [BW-1:0]   bx_n;
  logic [1:0]      colm_n;
  logic [AW-1:0]   by_n;
  logic [1:0]      rowm_n;
  logic            out_free;

  logic            raw_re;
  logic            raw_we;
  logic [RAW_AW-1:0] raw_raddr;
  logic [47:0]     raw_rdata;
  logic            acc_re;
  logic            acc_we;
  accs_t           acc_rdata;
  accs_t           acc_new;

  logic            fir_start;
  logic            fir_busy;
  logic            fir_done;
  rgb_win_t        fir_win;
  rgb_t            fir_res;

  state_t          adv_state;
  logic [1:0]      adv_m;
  logic [1:0]      adv_lane;

  // raw column used for tap k: columns c-4 .. c-1, clamped at the left edge
  function automatic logic [CW-1:0] raw_col(logic [CW-1:0] cc, logic [1:0] kk);
    logic [CW:0] s;
    s = (CW+1)'(cc) + (CW+1)'(kk);
    return (s >= (CW+1)'(4)) ? CW'(s - (CW+1)'(4)) : '0;
  endfunction

  assign w3       = (CW+1)'(3) * (CW+1)'(out_width);
  assign h3       = (RW+1)'(3) * (RW+1)'(out_height);
  assign last_col = ({1'b0, c} == w3 - (CW+1)'(1));
  assign last_row = ({1'b0, r} == h3 - (RW+1)'(1));
  assign lane_ok  = (lane == 2'd0) ? (c >= CW'(2)) : last_col;
  assign row_ok   = (m == 2'd0) ? (r >= RW'(2)) : last_row;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  assign rd_k    = (state == S_IDLE) ? 2'd0 : rk[1:0];
  assign cap_k   = 2'(rk - 3'd1);
  assign rd_col  = raw_col(c, rd_k);
  assign cap_col = raw_col(c, cap_k);

  assign raw_re    = (state == S_IDLE && s_tvalid) || (state == S_RAW && rk != 3'd4);
  assign raw_we    = (state == S_RAW && rk == 3'd4);
  assign raw_raddr = {rd_col[1:0], r};

  // block position of the column lane and row tap being processed
  assign dcol = 2'd2 - lane;
  assign drow = 2'd2 - m;
  always_comb begin
    if (cm >= dcol) begin
      bx_n = cq;
      colm_n = cm - dcol;
    end else begin
      bx_n = cq - BW'(1);
      colm_n = cm + 2'd3 - dcol;
    end
    if (rm >= drow) begin
      by_n = rq;
      rowm_n = rm - drow;
    end else begin
      by_n = rq - AW'(1);
      rowm_n = rm + 2'd3 - drow;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) ex[k] = e[k];
    for (int k = 4; k < 7; k++) ex[k] = cur;
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        if (state == S_LANE) fir_win[ch][j] = ex[3'(lane) + 3'(j)][ch];
        else fir_win[ch][j] = fbuf[3'(m) + 3'(j)][ch];
      end
    end
  end

  assign fir_start = (state == S_LANE && lane_ok) || (state == S_ROW && row_ok);

  assign acc_re = (state == S_ROW && row_ok);
  assign acc_we = (state == S_RFIR && fir_done);
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc_new[ch] = first_r ? ACC_BITS'(fir_res[ch])
                            : acc_rdata[ch] + ACC_BITS'(fir_res[ch]);
    end
  end

  always_comb begin
    adv_m = '0;
    adv_lane = lane;
    if (m != 2'd2) begin
      adv_state = S_ROW;
      adv_m = m + 2'd1;
    end else if (lane != 2'd2) begin
      adv_state = S_LANE;
      adv_lane = lane + 2'd1;
    end else begin
      adv_state = S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_width  <= WW'(1);
      out_height <= HW'(1);
      c <= '0; r <= '0; cq <= '0; cm <= '0; rq <= '0; rm <= '0;
      rk <= '0; lane <= '0; m <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OUT_WIDTH: begin
            if (cfg_data == '0) out_width <= WW'(1);
            else if (32'(cfg_data) > MAX_OUT_COLS) out_width <= WW'(MAX_OUT_COLS);
            else out_width <= WW'(cfg_data);
          end
          REG_OUT_HEIGHT: begin
            if (cfg_data == '0) out_height <= HW'(1);
            else if (32'(cfg_data) > MAX_OUT_ROWS) out_height <= HW'(MAX_OUT_ROWS);
            else out_height <= HW'(cfg_data);
          end
        endcase
        // restart the frame
        c <= '0; r <= '0; cq <= '0; cm <= '0; rq <= '0; rm <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur   <= rgb_t'(s_tdata[IN_DATA_W-1:0]);
            rk    <= 3'd1;
            state <= S_RAW;
          end
        end
        S_RAW: begin
          e[cap_k] <= (cap_col >= c) ? cur : rgb_t'(raw_rdata);
          if (rk == 3'd4) begin
            lane  <= '0;
            state <= S_LANE;
          end else begin
            rk <= rk + 3'd1;
          end
        end
        S_LANE: begin
          state <= lane_ok ? S_CFIR : S_FIN;
        end
        S_CFIR: begin
          if (fir_done) begin
            // first row fills the window with the edge value, then shift in
            for (int k = 0; k < 4; k++) fbuf[k] <= (r == '0) ? fir_res : rbw[lane][k];
            for (int k = 4; k < 7; k++) fbuf[k] <= fir_res;
            for (int k = 0; k < 3; k++) rbw[lane][k] <= (r == '0) ? fir_res : rbw[lane][k+1];
            rbw[lane][3] <= fir_res;
            m     <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (row_ok) begin
            by_r    <= by_n;
            bx_r    <= bx_n;
            first_r <= (colm_n == 2'd0) && (rowm_n == 2'd0);
            emit_r  <= (colm_n == 2'd2) && (rowm_n == 2'd2);
            state   <= S_RFIR;
          end else if (lane != 2'd2) begin
            lane  <= lane + 2'd1;
            state <= S_LANE;
          end else begin
            state <= S_FIN;
          end
        end
        S_RFIR: begin
          if (fir_done) begin
            if (emit_r) begin
              sums_r <= acc_new;
              state  <= S_DIV;
            end else begin
              m     <= adv_m;
              lane  <= adv_lane;
              state <= adv_state;
            end
          end
        end
        S_DIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            prod[ch] <= (41'(sums_r[ch]) + 41'd4) * 41'(DIV9_RECIP);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= {6'd0,
                         prod[2][DIV9_SHIFT +: CH_BITS],
                         prod[1][DIV9_SHIFT +: CH_BITS],
                         prod[0][DIV9_SHIFT +: CH_BITS],
                         9'(by_r), 9'(bx_r)};
            m_tlast  <= (32'(bx_r) == 32'(out_width) - 1) &&
                        (32'(by_r) == 32'(out_height) - 1);
            m     <= adv_m;
            lane  <= adv_lane;
            state <= adv_state;
          end
        end
        S_FIN: begin
          // advance sample position, wrap at frame end
          if ({1'b0, r} + (RW+1)'(1) >= h3) begin
            r <= '0; rq <= '0; rm <= '0;
            if ({1'b0, c} + (CW+1)'(1) >= w3) begin
              c <= '0; cq <= '0; cm <= '0;
            end else begin
              c <= c + CW'(1);
              if (cm == 2'd2) begin
                cm <= '0;
                cq <= cq + BW'(1);
              end else begin
                cm <= cm + 2'd1;
              end
            end
          end else begin
            r <= r + RW'(1);
            if (rm == 2'd2) begin
              rm <= '0;
              rq <= rq + AW'(1);
            end else begin
              rm <= rm + 2'd1;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gbd_ram #(.WIDTH(48), .DEPTH(1 << RAW_AW)) u_raw (
    .clk   (clk),
    .we    (raw_we),
    .waddr ({c[1:0], r}),
    .wdata (cur),
    .re    (raw_re),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  gbd_ram #(.WIDTH(3 * ACC_BITS), .DEPTH(MAX_OUT_ROWS)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (by_r),
    .wdata (acc_new),
    .re    (acc_re),
    .raddr (by_n),
    .rdata (acc_rdata)
  );

  gbd_fir u_fir (
    .clk    (clk),
    .rst    (rst),
    .start  (fir_start),
    .win    (fir_win),
    .busy   (fir_busy),
    .done   (fir_done),
    .result (fir_res)
  );

  `GBD_ASSERT_NEXT(a_accept_reads_raw, s_tvalid && s_tready, state == S_RAW,
                   "accepted item did not enter raw read")
  `GBD_ASSERT_NOW(a_fir_start_idle, fir_start, !fir_busy && !fir_done,
                  "filter started while busy")
  `GBD_ASSERT_NEXT(a_emit_loads_out, state == S_EMIT && out_free, m_tvalid,
                   "emitted result not presented")

endmodule

FILE: rtl/gbd_ram.sv
module gbd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/gbd_fir.sv
module gbd_fir (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gbd_pkg::rgb_win_t win,
  output logic              busy,
  output logic              done,
  output gbd_pkg::rgb_t     result
);
  import gbd_pkg::*;

  rgb_win_t               wreg;
  logic [2:0]             k;
  logic                   fin;
  logic [FIR_ACC_W-1:0]   acc  [3];
  logic [FIR_ACC_W-1:0]   rnd  [3];
  logic [30:0]            prod [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = 31'(GAUSS_TAPS[k]) * 31'(wreg[ch][k]);
      rnd[ch]  = acc[ch] + FIR_ACC_W'(32768);
    end
  end

  // one tap a cycle on all three channels, then round and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
        wreg <= win;
        for (int ch = 0; ch < 3; ch++) acc[ch] <= '0;
      end else if (busy) begin
        for (int ch = 0; ch < 3; ch++) acc[ch] <= acc[ch] + FIR_ACC_W'(prod[ch]);
        if (k == 3'(NUM_TAPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          k <= k + 3'd1;
        end
      end
      if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
          if (rnd[ch][FIR_ACC_W-1:16] > (FIR_ACC_W-16)'(CH_MAX)) result[ch] <= CH_MAX;
          else result[ch] <= rnd[ch][16 +: CH_BITS];
        end
      end
    end
  end

endmodule
